// File: design/assert_macros.svh
// Assertion macros used by the top level of the radix tree node splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rtns_pkg.sv
// Package with constants, types and helper functions of the radix tree node splitter.
`default_nettype none

package rtns_pkg;

  // Store geometry and derived widths.
  localparam int MAX_LEAVES = 1024;
  localparam int CODE_BITS  = 30;
  localparam int IDX_W      = $clog2(MAX_LEAVES);
  localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
  localparam int OFF_W      = IDX_W + 1;
  localparam int K_W        = IDX_W + 3;
  localparam int PL_W       = $clog2(CODE_BITS + 32 + 1) + 1;
  // Prefix length of two equal codes before the index tie-break term.
  localparam int TIE_BASE   = CODE_BITS + 32 - IDX_W;

  // Opcodes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NODE = 1'b1;

  // Sequencer states: each probe is a read state followed by an evaluate state.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_CAP,
    ST_UP_RD,
    ST_UP_EV,
    ST_DN_RD,
    ST_DN_EV,
    ST_GROW_RD,
    ST_GROW_EV,
    ST_BIN1_RD,
    ST_BIN1_EV,
    ST_JEND_RD,
    ST_JEND_EV,
    ST_BIN2_RD,
    ST_BIN2_EV,
    ST_DONE
  } rtns_state_e;

  // One input word.
  typedef struct packed {
    logic                 opcode;
    logic [IDX_W-1:0]     index;
    logic [CODE_BITS-1:0] code;
  } rtns_item_t;

  // Access request to the code store.
  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [CODE_BITS-1:0] wr_data;
  } rtns_mem_req_t;

  // One result word.
  typedef struct packed {
    logic [IDX_W-1:0] node_number;
    logic [IDX_W-1:0] split_index;
    logic [IDX_W-1:0] range_end;
    logic             goes_up;
    logic             left_leaf;
    logic             right_leaf;
  } rtns_result_t;

  // Leading zeros of a code-wide value.
  function automatic logic [PL_W-1:0] clz_code(input logic [CODE_BITS-1:0] x);
    logic [PL_W-1:0] n;
    n = PL_W'(CODE_BITS);
    for (int b = 0; b < CODE_BITS; b++) begin
      if (x[b]) begin
        n = PL_W'(CODE_BITS - 1 - b);
      end
    end
    return n;
  endfunction

  // Leading zeros of an index-wide value.
  function automatic logic [PL_W-1:0] clz_idx(input logic [IDX_W-1:0] x);
    logic [PL_W-1:0] n;
    n = PL_W'(IDX_W);
    for (int b = 0; b < IDX_W; b++) begin
      if (x[b]) begin
        n = PL_W'(IDX_W - 1 - b);
      end
    end
    return n;
  endfunction

  // Smallest power of two not below l, and one for l of zero.
  function automatic logic [OFF_W-1:0] next_pow2(input logic [IDX_W-1:0] l);
    logic [IDX_W-1:0] m;
    logic [OFF_W-1:0] r;
    m = l - IDX_W'(1);
    r = OFF_W'(1);
    if (l != '0) begin
      for (int b = 0; b < IDX_W; b++) begin
        if (m[b]) begin
          r      = '0;
          r[b+1] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/rtns_code_ram.sv
// Code store: one write port and one registered read port.
`default_nettype none

module rtns_code_ram (
  input  logic                           clk_i,
  input  rtns_pkg::rtns_mem_req_t        req_i,
  output logic [rtns_pkg::CODE_BITS-1:0] rd_data_o
);
  import rtns_pkg::*;

  logic [CODE_BITS-1:0] mem [MAX_LEAVES];
  logic [CODE_BITS-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/rtns_prefix.sv
// Common-prefix length of the node code and one probed code.
`default_nettype none

module rtns_prefix (
  input  logic [rtns_pkg::CODE_BITS-1:0] node_code_i,
  input  logic [rtns_pkg::CODE_BITS-1:0] probe_code_i,
  input  logic [rtns_pkg::IDX_W-1:0]     node_idx_i,
  input  logic [rtns_pkg::IDX_W-1:0]     probe_idx_i,
  input  logic                           in_range_i,
  output logic signed [rtns_pkg::PL_W-1:0] pl_o
);
  import rtns_pkg::*;

  logic [CODE_BITS-1:0] diff;

  assign diff = node_code_i ^ probe_code_i;

  // Out of range reads as minus one; equal codes fall back to the index bits.
  always_comb begin
    if (!in_range_i) begin
      pl_o = '1;
    end else if (diff != '0) begin
      pl_o = clz_code(diff);
    end else begin
      pl_o = PL_W'(TIE_BASE) + clz_idx(node_idx_i ^ probe_idx_i);
    end
  end

endmodule

`default_nettype wire

// File: design/rtns_seq.sv
// Sequencer and search datapath that probes the code store for one internal node.
`default_nettype none

module rtns_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  rtns_pkg::rtns_item_t           item_i,
  input  logic [rtns_pkg::CNT_W-1:0]     leaf_num_i,
  input  logic [rtns_pkg::CODE_BITS-1:0] rd_data_i,
  input  logic                           res_ready_i,
  output logic                           item_stall_o,
  output rtns_pkg::rtns_mem_req_t        mem_req_o,
  output logic                           res_valid_o,
  output rtns_pkg::rtns_result_t         res_o
);
  import rtns_pkg::*;

  rtns_state_e state_q, state_d;

  logic [IDX_W-1:0]       i_q, k_q, j_q, l_q, s_q;
  logic [CODE_BITS-1:0]   ci_q;
  logic                   inr_q, d_up_q;
  logic signed [PL_W-1:0] pl_up_q, dmin_q, dnode_q, pl;
  logic [OFF_W-1:0]       lmax_q, t_q;

  logic             item_acc, node_ok, rd_state, dir, inr, hit_dmin, hit_dnode, t_last;
  logic [OFF_W-1:0] off;
  logic [K_W-1:0]   k_w, split_w, lo_w, hi_w;

  assign item_acc  = item_valid_i && !item_stall_o;
  assign node_ok   = CNT_W'(item_i.index) < (leaf_num_i - CNT_W'(1));
  assign hit_dmin  = pl > dmin_q;
  assign hit_dnode = pl > dnode_q;
  assign t_last    = t_q == OFF_W'(1);

  // Prefix length of the word returned by the store.
  rtns_prefix u_prefix (
    .node_code_i  (ci_q),
    .probe_code_i (rd_data_i),
    .node_idx_i   (i_q),
    .probe_idx_i  (k_q),
    .in_range_i   (inr_q),
    .pl_o         (pl)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_acc && (item_i.opcode == OP_NODE) && node_ok) begin
          state_d = ST_NODE_RD;
        end
      end
      ST_NODE_RD:  state_d = ST_NODE_CAP;
      ST_NODE_CAP: state_d = ST_UP_RD;
      ST_UP_RD:    state_d = ST_UP_EV;
      ST_UP_EV:    state_d = ST_DN_RD;
      ST_DN_RD:    state_d = ST_DN_EV;
      ST_DN_EV:    state_d = ST_GROW_RD;
      ST_GROW_RD:  state_d = ST_GROW_EV;
      ST_GROW_EV:  state_d = hit_dmin ? ST_GROW_RD : ST_BIN1_RD;
      ST_BIN1_RD:  state_d = ST_BIN1_EV;
      ST_BIN1_EV:  state_d = t_last ? ST_JEND_RD : ST_BIN1_RD;
      ST_JEND_RD:  state_d = ST_JEND_EV;
      ST_JEND_EV:  state_d = ST_BIN2_RD;
      ST_BIN2_RD:  state_d = ST_BIN2_EV;
      ST_BIN2_EV:  state_d = t_last ? ST_DONE : ST_BIN2_RD;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control outputs: probe offset and direction for each read state, input stall and result valid.
  always_comb begin
    rd_state     = 1'b0;
    off          = '0;
    dir          = d_up_q;
    item_stall_o = 1'b1;
    res_valid_o  = 1'b0;
    case (state_q)
      ST_IDLE: item_stall_o = 1'b0;
      ST_NODE_RD: begin
        rd_state = 1'b1;
        dir      = 1'b1;
      end
      ST_UP_RD: begin
        rd_state = 1'b1;
        off      = OFF_W'(1);
        dir      = 1'b1;
      end
      ST_DN_RD: begin
        rd_state = 1'b1;
        off      = OFF_W'(1);
        dir      = 1'b0;
      end
      ST_GROW_RD: begin
        rd_state = 1'b1;
        off      = lmax_q;
      end
      ST_BIN1_RD: begin
        rd_state = 1'b1;
        off      = OFF_W'(l_q) + t_q;
      end
      ST_JEND_RD: begin
        rd_state = 1'b1;
        off      = OFF_W'(l_q);
      end
      ST_BIN2_RD: begin
        rd_state = 1'b1;
        off      = OFF_W'(s_q) + t_q;
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Probe address and range check.
  assign k_w = dir ? (K_W'(i_q) + K_W'(off)) : (K_W'(i_q) - K_W'(off));
  assign inr = !k_w[K_W-1] && (k_w < K_W'(leaf_num_i));

  // Store access: reads while searching, writes for load words.
  always_comb begin
    mem_req_o.rd_en   = rd_state && inr;
    mem_req_o.rd_addr = k_w[IDX_W-1:0];
    mem_req_o.wr_en   = item_acc && (item_i.opcode == OP_LOAD);
    mem_req_o.wr_addr = item_i.index;
    mem_req_o.wr_data = item_i.code;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search registers, updated at the end of the read or evaluate state of each probe.
  always_ff @(posedge clk_i) begin
    if (rd_state) begin
      k_q   <= k_w[IDX_W-1:0];
      inr_q <= inr;
    end
    case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          i_q <= item_i.index;
        end
      end
      ST_NODE_CAP: ci_q <= rd_data_i;
      ST_UP_EV:    pl_up_q <= pl;
      ST_DN_EV: begin
        d_up_q <= pl_up_q >= pl;
        dmin_q <= (pl_up_q >= pl) ? pl : pl_up_q;
        lmax_q <= OFF_W'(2);
      end
      ST_GROW_EV: begin
        if (hit_dmin) begin
          lmax_q <= lmax_q << 1;
        end else begin
          t_q <= lmax_q >> 1;
          l_q <= '0;
        end
      end
      ST_BIN1_EV: begin
        if (hit_dmin) begin
          l_q <= l_q + t_q[IDX_W-1:0];
        end
        t_q <= t_q >> 1;
      end
      ST_JEND_RD:  j_q <= k_w[IDX_W-1:0];
      ST_JEND_EV: begin
        dnode_q <= pl;
        t_q     <= next_pow2(l_q);
        s_q     <= '0;
      end
      ST_BIN2_EV: begin
        if (hit_dnode) begin
          s_q <= s_q + t_q[IDX_W-1:0];
        end
        t_q <= t_q >> 1;
      end
      default: ;
    endcase
  end

  // Split position and child leaf flags.
  assign split_w = d_up_q ? (K_W'(i_q) + K_W'(s_q)) : (K_W'(i_q) - K_W'(s_q) - K_W'(1));
  assign lo_w    = d_up_q ? K_W'(i_q) : K_W'(j_q);
  assign hi_w    = d_up_q ? K_W'(j_q) : K_W'(i_q);

  always_comb begin
    res_o.node_number = i_q;
    res_o.split_index = split_w[IDX_W-1:0];
    res_o.range_end   = j_q;
    res_o.goes_up     = d_up_q;
    res_o.left_leaf   = lo_w == split_w;
    res_o.right_leaf  = hi_w == (split_w + K_W'(1));
  end

endmodule

`default_nettype wire

// File: design/rtns_out_reg.sv
// Output register that holds one result word until the receiver takes it.
`default_nettype none

module rtns_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  input  rtns_pkg::rtns_result_t res_i,
  output logic                   res_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rtns_pkg::rtns_result_t out_o
);
  import rtns_pkg::*;

  logic         valid_q, valid_d;
  rtns_result_t data_q;

  // A new word may enter when the register is empty or being drained.
  assign res_ready_o = !valid_q || !out_stall_i;
  assign valid_d     = (res_valid_i && res_ready_o) || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

// File: design/radix_tree_node_split.sv
// Top level of the radix tree node splitter over sorted Morton codes.
`default_nettype none
`include "assert_macros.svh"

// Load words write one code into a 1024-entry store. A node word for internal node i
// (i below leaf_count-1) reads code i, then makes one probe of the store per step: two
// for the direction, one per doubling, one per step of the range search, one for the
// far end and one per step of the split search. Each probe is a store read state
// followed by an evaluate state, because the single read port returns registered
// data. With L = log2(leaf_count) rounded up, a node takes at most 3*L + 5 probes.
// The input stalls until the result has moved into the output register. A node word
// at or above leaf_count-1 is taken without a search and gives no result. leaf_count
// below 2 acts as 2, above 1024 as 1024.
module radix_tree_node_split (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rtns_pkg::CNT_W-1:0]     cfg_leaf_count_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [rtns_pkg::IDX_W-1:0]     item_index_i,
  input  logic [rtns_pkg::CODE_BITS-1:0] morton_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rtns_pkg::IDX_W-1:0]     node_number_o,
  output logic [rtns_pkg::IDX_W-1:0]     split_index_o,
  output logic [rtns_pkg::IDX_W-1:0]     range_end_o,
  output logic                           goes_up_o,
  output logic                           left_leaf_o,
  output logic                           right_leaf_o
);
  import rtns_pkg::*;

  logic [CNT_W-1:0]     leaf_count_q, leaf_count_d, leaf_num;
  rtns_item_t           item;
  rtns_mem_req_t        mem_req;
  logic [CODE_BITS-1:0] rd_data;
  logic                 res_valid, res_ready;
  rtns_result_t         res, out_res;

  // Leaf count register, always ready for a write.
  assign cfg_ready_o  = 1'b1;
  assign leaf_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_leaf_count_i : leaf_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= CNT_W'(2);
    end else begin
      leaf_count_q <= leaf_count_d;
    end
  end

  // Clamp the leaf count into the supported range.
  always_comb begin
    if (leaf_count_q < CNT_W'(2)) begin
      leaf_num = CNT_W'(2);
    end else if (leaf_count_q > CNT_W'(MAX_LEAVES)) begin
      leaf_num = CNT_W'(MAX_LEAVES);
    end else begin
      leaf_num = leaf_count_q;
    end
  end

  // Input word.
  always_comb begin
    item.opcode = opcode_i;
    item.index  = item_index_i;
    item.code   = morton_value_i;
  end

  rtns_code_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  rtns_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .item_i       (item),
    .leaf_num_i   (leaf_num),
    .rd_data_i    (rd_data),
    .res_ready_i  (res_ready),
    .item_stall_o (in_stall_o),
    .mem_req_o    (mem_req),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  rtns_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  // Result word fields.
  assign node_number_o = out_res.node_number;
  assign split_index_o = out_res.split_index;
  assign range_end_o   = out_res.range_end;
  assign goes_up_o     = out_res.goes_up;
  assign left_leaf_o   = out_res.left_leaf;
  assign right_leaf_o  = out_res.right_leaf;

  // Node zero is always inside the tree, so accepting it must start a search.
  `RTNS_ASSERT_NEXT(a_node_zero_busy, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && (opcode_i == OP_NODE) && (item_index_i == '0),
                    in_stall_o, "node word did not start a search")
  // A load word never produces a result.
  `RTNS_ASSERT_NEXT(a_load_silent, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && (opcode_i == OP_LOAD) && !out_valid_o,
                    !out_valid_o, "load word produced a result")
  // A finished result waits unchanged until the output register takes it.
  `RTNS_ASSERT_NEXT(a_res_held, clk_i, rst_ni, res_valid && !res_ready,
                    res_valid && $stable(res), "pending result lost or changed")

endmodule

`default_nettype wire

// File: tb/tb_radix_tree_node_split.sv
// Self-checking testbench of the radix tree node splitter with its own node predictor.
`timescale 1ns / 1ps

module tb_radix_tree_node_split;
  import rtns_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int LIMIT       = 2_000_000;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL        = 50;
  localparam int CODE_MASK   = (1 << CODE_BITS) - 1;

  // Tracks the code store and leaf count, predicts each node and checks the results.
  class node_split_board;
    logic [CODE_BITS-1:0] leaf_codes [MAX_LEAVES];
    int                   leaves = 2;
    int                   errors = 0;
    rtns_result_t         expected_nodes [$];

    // Out-of-range settings act as the nearest legal leaf count.
    function void set_leaves(int value);
      if (value < 2) begin
        leaves = 2;
      end else if (value > MAX_LEAVES) begin
        leaves = MAX_LEAVES;
      end else begin
        leaves = value;
      end
    endfunction

    function int pending();
      return expected_nodes.size();
    endfunction

    function int count_leading(logic [31:0] x, int width);
      int n;
      n = 0;
      for (int b = width - 1; b >= 0; b--) begin
        if (x[b]) break;
        n++;
      end
      return n;
    endfunction

    // Common prefix length of two leaves; equal codes fall back on their indexes.
    function int common_prefix(int a, int k);
      logic [CODE_BITS-1:0] x;
      if (a < 0 || a >= leaves || k < 0 || k >= leaves) return -1;
      x = leaf_codes[a] ^ leaf_codes[k];
      if (x != '0) return count_leading(32'(x), CODE_BITS);
      return CODE_BITS + count_leading(32'(a ^ k), 32);
    endfunction

    // Direction, far end and split of internal node i.
    function void predict_node(int i);
      int d, dmin, dnode, lmax, l, t, j, s, split, lo, hi;
      rtns_result_t r;
      d = (common_prefix(i, i + 1) - common_prefix(i, i - 1) < 0) ? -1 : 1;
      dmin = common_prefix(i, i - d);
      lmax = 2;
      while (common_prefix(i, i + lmax * d) > dmin) lmax *= 2;
      l = 0;
      t = lmax / 2;
      while (t >= 1) begin
        if (common_prefix(i, i + (l + t) * d) > dmin) l += t;
        t = t / 2;
      end
      j = i + l * d;
      dnode = common_prefix(i, j);
      t = 1;
      while (t < l) t *= 2;
      s = 0;
      while (t >= 1) begin
        if (common_prefix(i, i + (s + t) * d) > dnode) s += t;
        t = t / 2;
      end
      split = i + s * d + ((d < 0) ? -1 : 0);
      lo = (i < j) ? i : j;
      hi = (i > j) ? i : j;
      r.node_number = IDX_W'(i);
      r.split_index = IDX_W'(split);
      r.range_end   = IDX_W'(j);
      r.goes_up     = (d > 0);
      r.left_leaf   = (lo == split);
      r.right_leaf  = (hi == split + 1);
      expected_nodes.push_back(r);
    endfunction

    // Called for every accepted input word, in acceptance order.
    function void note_item(logic op, logic [IDX_W-1:0] idx, logic [CODE_BITS-1:0] code);
      if (op == OP_LOAD) begin
        leaf_codes[idx] = code;
      end else if (int'(idx) < leaves - 1) begin
        predict_node(int'(idx));
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rtns_result_t got);
      rtns_result_t want;
      if (expected_nodes.size() == 0) begin
        $display("%0t: result expected none got node %0d", $time, got.node_number);
        errors++;
        return;
      end
      want = expected_nodes.pop_front();
      compare_field("node_number", want.node_number, got.node_number);
      compare_field("split_index", want.split_index, got.split_index);
      compare_field("range_end", want.range_end, got.range_end);
      compare_field("goes_up", want.goes_up, got.goes_up);
      compare_field("left_leaf", want.left_leaf, got.left_leaf);
      compare_field("right_leaf", want.right_leaf, got.right_leaf);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CNT_W-1:0]     cfg_leaf_count_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [IDX_W-1:0]     item_index_i;
  logic [CODE_BITS-1:0] morton_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [IDX_W-1:0]     node_number_o;
  logic [IDX_W-1:0]     split_index_o;
  logic [IDX_W-1:0]     range_end_o;
  logic                 goes_up_o;
  logic                 left_leaf_o;
  logic                 right_leaf_o;

  node_split_board sb = new();
  rtns_result_t    seen_result;
  bit              calm = 1'b0;
  bit              hold_out = 1'b0;
  int              sent = 0;
  int              cycles = 0;

  radix_tree_node_split dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_leaf_count_i(cfg_leaf_count_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .item_index_i    (item_index_i),
    .morton_value_i  (morton_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .node_number_o   (node_number_o),
    .split_index_o   (split_index_o),
    .range_end_o     (range_end_o),
    .goes_up_o       (goes_up_o),
    .left_leaf_o     (left_leaf_o),
    .right_leaf_o    (right_leaf_o)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  assign seen_result = {node_number_o, split_index_o, range_end_o,
                        goes_up_o, left_leaf_o, right_leaf_o};

  // Every result word taken by the receiver is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(seen_result);
    end
  end

  // Receiver: a random stall before each word, or one long hold when asked.
  initial begin
    int w;
    out_stall_i = 1'b0;
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        w = HOLD_CYCLES;
      end else begin
        w = calm ? 0 : $urandom_range(0, 8);
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one word after a random gap and waits until the block takes it.
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [CODE_BITS-1:0] code);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    item_index_i   <= idx;
    morton_value_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, idx, code);
    sent++;
  endtask

  // The leaf count is written only once the block has gone idle.
  task automatic program_leaf_count(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_leaf_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_leaves(int'(value));
  endtask

  // Fills leaves 0..count-1, either ascending with duplicates or scrambled.
  task automatic load_codes(input int count, input bit sorted);
    int maxstep, lim, v;
    maxstep = CODE_MASK / (count + 1);
    lim = maxstep >> (6 * $urandom_range(0, 3));
    if (lim < 1) lim = 1;
    v = $urandom_range(0, maxstep);
    for (int k = 0; k < count; k++) begin
      if (!sorted && $urandom_range(0, 3) != 0) v = int'($urandom() & CODE_MASK);
      send_item(OP_LOAD, IDX_W'(k), CODE_BITS'(v));
      if (sorted && $urandom_range(0, 4) != 0) v += $urandom_range(1, lim);
    end
  endtask

  // One setting of the leaf count: optional reload, then mostly node queries.
  task automatic run_phase(input int leaves_cfg, input bit reload, input bit sorted,
                           input int queries, input bit hold);
    int eff, r;
    program_leaf_count(CNT_W'(leaves_cfg));
    eff = sb.leaves;
    calm = ($urandom_range(0, 3) == 0);
    if (reload) load_codes(eff, sorted);
    if (hold) hold_out = 1'b1;
    repeat (queries) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_item(OP_NODE, IDX_W'($urandom_range(eff - 1, MAX_LEAVES - 1)),
                  CODE_BITS'($urandom()));
      end else if (r == 1) begin
        send_item(OP_LOAD, IDX_W'($urandom_range(0, MAX_LEAVES - 1)),
                  CODE_BITS'($urandom()));
      end else begin
        send_item(OP_NODE, IDX_W'($urandom_range(0, eff - 2)), CODE_BITS'($urandom()));
      end
    end
  endtask

  initial begin
    int n;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_leaf_count_i = '0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_LOAD;
    item_index_i     = '0;
    morton_value_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two leaves at the reset count: equal codes, then the widest code.
    send_item(OP_LOAD, IDX_W'(0), '0);
    send_item(OP_LOAD, IDX_W'(1), '0);
    send_item(OP_NODE, IDX_W'(0), '1);
    send_item(OP_NODE, IDX_W'(1), '0);
    send_item(OP_NODE, '1, '0);
    send_item(OP_LOAD, IDX_W'(1), '1);
    send_item(OP_NODE, IDX_W'(0), '0);

    // Eight sorted leaves with runs of duplicates and both code extremes.
    program_leaf_count(CNT_W'(8));
    send_item(OP_LOAD, IDX_W'(0), '0);
    send_item(OP_LOAD, IDX_W'(1), '0);
    send_item(OP_LOAD, IDX_W'(2), '0);
    send_item(OP_LOAD, IDX_W'(3), CODE_BITS'(5));
    send_item(OP_LOAD, IDX_W'(4), CODE_BITS'(5));
    send_item(OP_LOAD, IDX_W'(5), CODE_BITS'(30'h2000_0000));
    send_item(OP_LOAD, IDX_W'(6), '1);
    send_item(OP_LOAD, IDX_W'(7), '1);
    send_item(OP_NODE, IDX_W'(0), '0);
    send_item(OP_NODE, IDX_W'(2), '0);
    send_item(OP_NODE, IDX_W'(4), '0);
    send_item(OP_NODE, IDX_W'(5), '0);
    send_item(OP_NODE, IDX_W'(6), '0);
    send_item(OP_NODE, IDX_W'(7), '0);
    // Breaking the order makes node 3 see the same prefix on both sides.
    send_item(OP_LOAD, IDX_W'(3), '1);
    send_item(OP_NODE, IDX_W'(3), '0);
    send_item(OP_NODE, IDX_W'(2), '0);

    // Random phases, mostly small trees with sorted codes.
    run_phase(2, 1'b1, 1'b1, 6, 1'b0);
    while (sent < 80) begin
      n = $urandom_range(0, 9);
      if (n < 6) begin
        n = $urandom_range(2, 16);
      end else if (n < 9) begin
        n = $urandom_range(17, 100);
      end else begin
        n = $urandom_range(101, 300);
      end
      run_phase(n, 1'b1, $urandom_range(0, 4) != 0, $urandom_range(n, 2 * n) % 81 + 2,
                1'b0);
    end

    // The full tree, with one long hold on the result side.
    run_phase(MAX_LEAVES, 1'b1, 1'b1, 60, 1'b1);
    // Leaf counts outside the legal range reuse the codes already stored.
    run_phase((1 << CNT_W) - 1, 1'b0, 1'b1, 40, 1'b0);
    run_phase(0, 1'b0, 1'b1, 10, 1'b0);
    run_phase(1, 1'b0, 1'b1, 10, 1'b0);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/rtns_pkg.sv
design/rtns_code_ram.sv
design/rtns_prefix.sv
design/rtns_seq.sv
design/rtns_out_reg.sv
design/radix_tree_node_split.sv
tb/tb_radix_tree_node_split.sv
